@@ hw/rtl/cst_pkg.sv @@
// cst_pkg: widths, token kinds, scan modes and character-class helpers
// for the character stream tokenizer; no dependencies
`default_nettype none

package cst_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 16;
    localparam int LENGTH_BITS = 8;

    localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE   = LINE_BITS'(1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = PTR_BITS + 1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_EOF,
        KIND_ASSIGN,
        KIND_PLUS,
        KIND_STAR,
        KIND_SLASH,
        KIND_COMMA,
        KIND_SEMI,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_LBRACE,
        KIND_RBRACE,
        KIND_INT,
        KIND_IDENT,
        KIND_FUNCTION,
        KIND_LET,
        KIND_ILLEGAL
    } token_kind_t;

    // keyword prefix progress codes
    localparam logic [3:0] KW_NONE       = 4'd0;
    localparam logic [3:0] KW_FUNC_FIRST = 4'd1;
    localparam logic [3:0] KW_FUNC_LAST  = 4'd7;
    localparam logic [3:0] KW_FUNC_DONE  = 4'd8;
    localparam logic [3:0] KW_LET_FIRST  = 4'd9;
    localparam logic [3:0] KW_LET_LAST   = 4'd10;
    localparam logic [3:0] KW_LET_DONE   = 4'd11;

    localparam logic [7:0] KW_FUNCTION [8] = '{8'h66, 8'h75, 8'h6e, 8'h63,
                                               8'h74, 8'h69, 8'h6f, 8'h6e};
    localparam logic [7:0] KW_LET [3] = '{8'h6c, 8'h65, 8'h74};

    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_NUL        = 8'h00;

    typedef struct packed {
        token_kind_t              kind;
        logic [OFFSET_BITS-1:0]   start;
        logic [LENGTH_BITS-1:0]   length;
        logic [LINE_BITS-1:0]     line;
        logic [LINE_BITS-1:0]     column;
        logic                     last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    // KIND_EOF means not a punctuator
    function automatic token_kind_t punct_kind(input logic [7:0] c);
        token_kind_t k;
        case (c)
            8'h3d:   k = KIND_ASSIGN;
            8'h2b:   k = KIND_PLUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_SLASH;
            8'h2c:   k = KIND_COMMA;
            8'h3b:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] kw_start(input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        if (c == KW_FUNCTION[0])
            r = KW_FUNC_FIRST;
        else if (c == KW_LET[0])
            r = KW_LET_FIRST;
        return r;
    endfunction

    function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        if ((p >= KW_FUNC_FIRST) && (p <= KW_FUNC_LAST))
        begin
            if (c == KW_FUNCTION[p[2:0]])
                r = p + 4'd1;
        end
        else if ((p == KW_LET_FIRST) || (p == KW_LET_LAST))
        begin
            // progress 9 and 10 select the second and third letter
            if (c == KW_LET[p[1:0]])
                r = p + 4'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/char_stream_tokenizer.sv @@
// char_stream_tokenizer: byte-serial lexer with a small token queue
// depends on cst_pkg
`default_nettype none
//
//  channel  handshake            beat contents
//  -------  -------------------  ------------------------------------------------
//  input    in_valid, in_ready   ch, end_of_input
//  output   out_valid, out_ready token_kind, token_start, token_length,
//                                token_line, token_column, last_of_run
//
//  one byte is lexed per cycle while in_ready is high; scan state updates in the accepting cycle
//  each byte queues zero, one or two tokens in a four-entry token queue
//  tokens leave one per cycle while out_ready is high, so bytes that close
//  a run and also emit a token of their own put two beats on the output
//  in_ready is high while the queue holds two tokens or fewer
//  rst_n clears scan state, position (line and column to one) and the queue

module char_stream_tokenizer
    import cst_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [7:0]             ch,
    input  wire logic                   end_of_input,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [3:0]             token_kind,
    output      logic [OFFSET_BITS-1:0] token_start,
    output      logic [LENGTH_BITS-1:0] token_length,
    output      logic [LINE_BITS-1:0]   token_line,
    output      logic [LINE_BITS-1:0]   token_column,
    output      logic                   last_of_run
);

    scan_mode_t             mode_reg, mode_next;
    logic [3:0]             kw_reg, kw_next_v;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [OFFSET_BITS-1:0] rs_offset_reg, rs_offset_next;
    logic [LINE_BITS-1:0]   rs_line_reg, rs_line_next;
    logic [LINE_BITS-1:0]   rs_col_reg, rs_col_next;
    logic [LENGTH_BITS-1:0] rlen_reg, rlen_next;

    token_t                 fifo_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    logic        accept, pop;
    logic        eoi, run_active, cont_run, do_close, has_own;
    logic        c_digit, c_alpha, c_under, c_space;
    token_kind_t pk, close_kind;
    token_t      close_tok, own_tok, first_tok;
    logic [1:0]  n_tok;
    token_t      head;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    assign c_digit = is_digit(ch);
    assign c_alpha = is_alpha(ch);
    assign c_under = (ch == CH_UNDERSCORE);
    assign c_space = is_space(ch);
    assign pk      = punct_kind(ch);
    assign eoi     = end_of_input || (ch == CH_NUL);

    assign run_active = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT);
    assign cont_run   = !eoi && (((mode_reg == MODE_NUM) && c_digit) ||
                        ((mode_reg == MODE_IDENT) && (c_alpha || c_digit || c_under)));
    assign do_close   = run_active && !cont_run;

    // next scan state and position
    always_comb
    begin
        mode_next      = mode_reg;
        kw_next_v      = kw_reg;
        offset_next    = offset_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        rs_offset_next = rs_offset_reg;
        rs_line_next   = rs_line_reg;
        rs_col_next    = rs_col_reg;
        rlen_next      = rlen_reg;
        if (eoi)
        begin
            mode_next = MODE_IDLE;
            kw_next_v = KW_NONE;
        end
        else
        begin
            offset_next = offset_reg + OFFSET_BITS'(1);
            if (ch == CH_NEWLINE)
            begin
                if (line_reg != LINE_MAX)
                    line_next = line_reg + LINE_ONE;
                col_next = LINE_ONE;
            end
            else if (col_reg != LINE_MAX)
            begin
                col_next = col_reg + LINE_ONE;
            end

            if (cont_run)
            begin
                if (rlen_reg != LENGTH_MAX)
                    rlen_next = rlen_reg + LENGTH_BITS'(1);
                if (mode_reg == MODE_IDENT)
                    kw_next_v = kw_next(kw_reg, ch);
            end
            else if (!c_space && (pk == KIND_EOF) && (c_digit || c_alpha || c_under))
            begin
                mode_next      = c_digit ? MODE_NUM : MODE_IDENT;
                kw_next_v      = c_digit ? KW_NONE : kw_start(ch);
                rs_offset_next = offset_reg;
                rs_line_next   = line_reg;
                rs_col_next    = col_reg;
                rlen_next      = LENGTH_BITS'(1);
            end
            else
            begin
                mode_next = MODE_IDLE;
                kw_next_v = KW_NONE;
            end
        end
    end

    // tokens caused by the current byte
    always_comb
    begin
        case (mode_reg)
            MODE_NUM:   close_kind = KIND_INT;
            MODE_IDENT:
            begin
                if (kw_reg == KW_FUNC_DONE)
                    close_kind = KIND_FUNCTION;
                else if (kw_reg == KW_LET_DONE)
                    close_kind = KIND_LET;
                else
                    close_kind = KIND_IDENT;
            end
            default:    close_kind = KIND_IDENT;
        endcase

        has_own = eoi || (!cont_run && !c_space &&
                          ((pk != KIND_EOF) || !(c_digit || c_alpha || c_under)));

        close_tok.kind   = close_kind;
        close_tok.start  = rs_offset_reg;
        close_tok.length = rlen_reg;
        close_tok.line   = rs_line_reg;
        close_tok.column = rs_col_reg;
        close_tok.last   = !has_own;

        if (eoi)
            own_tok.kind = KIND_EOF;
        else if (pk != KIND_EOF)
            own_tok.kind = pk;
        else
            own_tok.kind = KIND_ILLEGAL;
        own_tok.start  = offset_reg;
        own_tok.length = eoi ? LENGTH_BITS'(0) : LENGTH_BITS'(1);
        own_tok.line   = line_reg;
        own_tok.column = col_reg;
        own_tok.last   = 1'b1;

        first_tok = do_close ? close_tok : own_tok;
        n_tok     = {1'b0, do_close} + {1'b0, has_own};
    end

    // queue control
    always_comb
    begin
        in_ready    = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
            wr_ptr_next = wr_ptr_reg + PTR_BITS'(n_tok);
        if (pop)
            rd_ptr_next = rd_ptr_reg + PTR_BITS'(1);
        count_next = count_reg + (accept ? CNT_BITS'(n_tok) : CNT_BITS'(0))
                     - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            kw_reg        <= KW_NONE;
            offset_reg    <= '0;
            line_reg      <= LINE_ONE;
            col_reg       <= LINE_ONE;
            rs_offset_reg <= '0;
            rs_line_reg   <= LINE_ONE;
            rs_col_reg    <= LINE_ONE;
            rlen_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                kw_reg        <= kw_next_v;
                offset_reg    <= offset_next;
                line_reg      <= line_next;
                col_reg       <= col_next;
                rs_offset_reg <= rs_offset_next;
                rs_line_reg   <= rs_line_next;
                rs_col_reg    <= rs_col_next;
                rlen_reg      <= rlen_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token queue storage
    always_ff @(posedge clk)
    begin
        if (accept && (n_tok != 2'd0))
            fifo_mem[wr_ptr_reg] <= first_tok;
        if (accept && (n_tok == 2'd2))
            fifo_mem[wr_ptr_reg + PTR_BITS'(1)] <= own_tok;
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign token_line   = head.line;
    assign token_column = head.column;
    assign last_of_run  = head.last;

endmodule

`default_nettype wire

@@ tb/char_stream_tokenizer_tb.sv @@
// char_stream_tokenizer_tb: self-checking bench for the byte-serial tokenizer
// walks a directed table, then random lexeme streams, checking every token beat
// against an in-bench lexer or fixed table tokens; depends on cst_pkg and the rtl
`timescale 1ns / 100ps

module char_stream_tokenizer_tb
    import cst_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES = 175;

    typedef struct packed {
        logic [7:0] c;
        logic       eoi;
        logic       fixed;
        token_t     tok;
    } stim_row_t;

    localparam token_t NO_TOK = '{KIND_EOF, 24'd0, 8'd0, 16'd0, 16'd0, 1'b0};

    localparam stim_row_t DIRECTED [27] = '{
        '{"=", 1'b0, 1'b1, '{KIND_ASSIGN, 24'd0, 8'd1, 16'd1, 16'd1, 1'b1}},
        '{"+", 1'b0, 1'b1, '{KIND_PLUS,   24'd1, 8'd1, 16'd1, 16'd2, 1'b1}},
        '{"*", 1'b0, 1'b1, '{KIND_STAR,   24'd2, 8'd1, 16'd1, 16'd3, 1'b1}},
        '{"/", 1'b0, 1'b1, '{KIND_SLASH,  24'd3, 8'd1, 16'd1, 16'd4, 1'b1}},
        '{",", 1'b0, 1'b1, '{KIND_COMMA,  24'd4, 8'd1, 16'd1, 16'd5, 1'b1}},
        '{";", 1'b0, 1'b1, '{KIND_SEMI,   24'd5, 8'd1, 16'd1, 16'd6, 1'b1}},
        '{"l", 1'b0, 1'b0, NO_TOK},
        '{"e", 1'b0, 1'b0, NO_TOK},
        '{"t", 1'b0, 1'b0, NO_TOK},
        '{"(", 1'b0, 1'b0, NO_TOK},
        '{"f", 1'b0, 1'b0, NO_TOK},
        '{"u", 1'b0, 1'b0, NO_TOK},
        '{"n", 1'b0, 1'b0, NO_TOK},
        '{"c", 1'b0, 1'b0, NO_TOK},
        '{"t", 1'b0, 1'b0, NO_TOK},
        '{"i", 1'b0, 1'b0, NO_TOK},
        '{"o", 1'b0, 1'b0, NO_TOK},
        '{"n", 1'b0, 1'b0, NO_TOK},
        '{")", 1'b0, 1'b0, NO_TOK},
        '{"{", 1'b0, 1'b1, '{KIND_LBRACE, 24'd19, 8'd1, 16'd1, 16'd20, 1'b1}},
        '{"}", 1'b0, 1'b1, '{KIND_RBRACE, 24'd20, 8'd1, 16'd1, 16'd21, 1'b1}},
        '{"9", 1'b0, 1'b0, NO_TOK},
        '{"_", 1'b0, 1'b0, NO_TOK},
        '{8'hff, 1'b0, 1'b0, NO_TOK},
        '{CH_NEWLINE, 1'b0, 1'b0, NO_TOK},
        '{CH_NUL, 1'b0, 1'b1, '{KIND_EOF, 24'd25, 8'd0, 16'd2, 16'd1, 1'b1}},
        '{"A", 1'b1, 1'b1, '{KIND_EOF, 24'd25, 8'd0, 16'd2, 16'd1, 1'b1}}
    };

    localparam string SYMBOLS = "=+*/,;(){}";
    // letters and underscore first, then digits
    localparam string WORD_CH =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             ch;
    logic                   end_of_input;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             token_kind;
    logic [OFFSET_BITS-1:0] token_start;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   token_line;
    logic [LINE_BITS-1:0]   token_column;
    logic                   last_of_run;

    logic   row_fixed;
    token_t row_tok;

    int send_idle = 0;
    int recv_idle = 0;
    int bytes_sent = 0;
    int mismatches = 0;
    int cycles = 0;

    string word_shapes [10] = '{"function", "let", "let", "function", "fun",
                                "functions", "le", "lets", "f", "functio_n"};

    // lexer state mirrored by the bench
    scan_mode_t             lx_mode = MODE_IDLE;
    logic [3:0]             lx_kw = KW_NONE;
    logic [OFFSET_BITS-1:0] lx_off = '0;
    logic [LINE_BITS-1:0]   lx_line = LINE_ONE;
    logic [LINE_BITS-1:0]   lx_col = LINE_ONE;
    logic [OFFSET_BITS-1:0] lx_run_off = '0;
    logic [LINE_BITS-1:0]   lx_run_line = LINE_ONE;
    logic [LINE_BITS-1:0]   lx_run_col = LINE_ONE;
    logic [LENGTH_BITS-1:0] lx_run_len = '0;

    token_t step_toks [2];
    int     step_cnt;
    token_t tokens_due [$];

    char_stream_tokenizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .token_column (token_column),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic bit is_ws(input logic [7:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic token_kind_t sym_kind(input logic [7:0] c);
        token_kind_t k;
        case (c)
            "=":     k = KIND_ASSIGN;
            "+":     k = KIND_PLUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    task automatic add_tok(input token_kind_t kind, input logic [OFFSET_BITS-1:0] start,
                           input logic [LENGTH_BITS-1:0] len, input logic [LINE_BITS-1:0] line,
                           input logic [LINE_BITS-1:0] col);
        step_toks[step_cnt] = '{kind, start, len, line, col, 1'b0};
        step_cnt++;
    endtask

    task automatic close_run();
        token_kind_t kind;
        if (lx_mode == MODE_NUM)
            kind = KIND_INT;
        else if (lx_kw == KW_FUNC_DONE)
            kind = KIND_FUNCTION;
        else if (lx_kw == KW_LET_DONE)
            kind = KIND_LET;
        else
            kind = KIND_IDENT;
        add_tok(kind, lx_run_off, lx_run_len, lx_run_line, lx_run_col);
        lx_mode = MODE_IDLE;
        lx_kw = KW_NONE;
    endtask

    task automatic open_run(input scan_mode_t mode, input logic [3:0] kw);
        lx_mode = mode;
        lx_kw = kw;
        lx_run_off = lx_off;
        lx_run_line = lx_line;
        lx_run_col = lx_col;
        lx_run_len = 8'd1;
    endtask

    // tokens caused by one byte go to step_toks
    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        bit          in_run;
        token_kind_t sk;
        step_cnt = 0;
        in_run = 1'b0;
        sk = sym_kind(c);
        if (eoi || c == CH_NUL)
        begin
            if (lx_mode != MODE_IDLE)
                close_run();
            add_tok(KIND_EOF, lx_off, '0, lx_line, lx_col);
            lx_mode = MODE_IDLE;
            lx_kw = KW_NONE;
        end
        else
        begin
            if (lx_mode == MODE_NUM)
            begin
                if (is_dec(c))
                    in_run = 1'b1;
                else
                    close_run();
            end
            else if (lx_mode == MODE_IDENT)
            begin
                if (is_letter(c) || is_dec(c) || c == CH_UNDERSCORE)
                begin
                    in_run = 1'b1;
                    if (lx_kw >= KW_FUNC_FIRST && lx_kw <= KW_FUNC_LAST)
                        lx_kw = (c == KW_FUNCTION[lx_kw]) ? lx_kw + 4'd1 : KW_NONE;
                    else if (lx_kw == KW_LET_FIRST || lx_kw == KW_LET_LAST)
                        lx_kw = (c == KW_LET[lx_kw - KW_LET_FIRST + 1]) ? lx_kw + 4'd1 : KW_NONE;
                    else
                        lx_kw = KW_NONE;
                end
                else
                    close_run();
            end
            if (in_run)
            begin
                if (lx_run_len < LENGTH_MAX)
                    lx_run_len++;
            end
            else if (!is_ws(c))
            begin
                if (sk != KIND_EOF)
                    add_tok(sk, lx_off, 8'd1, lx_line, lx_col);
                else if (is_dec(c))
                    open_run(MODE_NUM, KW_NONE);
                else if (is_letter(c) || c == CH_UNDERSCORE)
                    open_run(MODE_IDENT, (c == KW_FUNCTION[0]) ? KW_FUNC_FIRST :
                                         (c == KW_LET[0]) ? KW_LET_FIRST : KW_NONE);
                else
                    add_tok(KIND_ILLEGAL, lx_off, 8'd1, lx_line, lx_col);
            end
            lx_off = lx_off + 1'b1;
            if (c == CH_NEWLINE)
            begin
                if (lx_line < LINE_MAX)
                    lx_line++;
                lx_col = LINE_ONE;
            end
            else if (lx_col < LINE_MAX)
                lx_col++;
        end
        if (step_cnt > 0)
            step_toks[step_cnt-1].last = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    $error("token beat with nothing expected, kind %0d", token_kind);
                    mismatches++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.kind, token_kind);
                    check_field("token_start", want.start, token_start);
                    check_field("token_length", want.length, token_length);
                    check_field("token_line", want.line, token_line);
                    check_field("token_column", want.column, token_column);
                    check_field("last_of_run", want.last, last_of_run);
                end
            end
            if (in_valid && in_ready)
            begin
                lex_byte(ch, end_of_input);
                if (row_fixed)
                begin
                    step_toks[0] = row_tok;
                    step_cnt = 1;
                end
                for (int i = 0; i < step_cnt; i++)
                    tokens_due.push_back(step_toks[i]);
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic e = 1'b0,
                             input logic f = 1'b0, input token_t t = NO_TOK);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_input <= e;
        row_fixed <= f;
        row_tok <= t;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_lexeme();
        int n;
        int pick;
        pick = $urandom_range(19);
        if (pick < 4)
            send_byte(SYMBOLS[$urandom_range(9)]);
        else if (pick < 7)
        begin
            n = ($urandom_range(59) == 0) ? $urandom_range(300, 256) : $urandom_range(5, 1);
            repeat (n)
                send_byte(8'("0" + $urandom_range(9)));
        end
        else if (pick < 11)
        begin
            n = ($urandom_range(59) == 0) ? $urandom_range(300, 256) : $urandom_range(7, 1);
            send_byte(WORD_CH[$urandom_range(52)]);
            repeat (n - 1)
                send_byte(WORD_CH[$urandom_range(62)]);
        end
        else if (pick < 14)
            send_text(word_shapes[$urandom_range(9)]);
        else if (pick < 16)
            send_byte($urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9)));
        else if (pick < 18)
            send_byte(8'($urandom_range(255)), ($urandom_range(5) == 0));
        else if (pick == 18)
            send_byte($urandom_range(1) ? CH_NUL : 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        else
            send_byte(CH_NEWLINE);
        if ($urandom_range(1))
            send_byte(" ");
    endtask

    initial
    begin
        int goal;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'h00;
        end_of_input = 1'b0;
        out_ready = 1'b0;
        row_fixed = 1'b0;
        row_tok = NO_TOK;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 34;
        recv_idle = 74;
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].c, DIRECTED[i].eoi, DIRECTED[i].fixed, DIRECTED[i].tok);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 74 : 0;
            recv_idle = (ph == 0) ? 74 : (ph == 1) ? 34 : 0;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                send_lexeme();
        end
        in_valid <= 1'b0;

        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
